/* rtl/core/cle_pkg.sv */
// Package for the console line editor: types, character codes and pointer arithmetic.
// Depends on nothing; every other file of the block but cle_ram imports it.
`default_nettype none

package cle_pkg;

  localparam int BUF_DEPTH = 128;
  localparam int PTR_SPAN = 2 * BUF_DEPTH;
  localparam int PTR_W = $clog2(PTR_SPAN);
  localparam int SLOT_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CTRL_D = 8'h04;
  localparam logic [7:0] CH_CTRL_H = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_CTRL_P = 8'h10;
  localparam logic [7:0] CH_CTRL_U = 8'h15;
  localparam logic [7:0] CH_DEL    = 8'h7f;

  localparam logic [1:0] RD_NONE  = 2'd0;
  localparam logic [1:0] RD_BYTE  = 2'd1;
  localparam logic [1:0] RD_EOF   = 2'd2;
  localparam logic [1:0] RD_EMPTY = 2'd3;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] in_char;
    logic       first_of_read;
  } in_item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic [7:0] erase_count;
    logic       committed;
    logic [1:0] read_status;
    logic [7:0] read_byte;
    logic       line_end;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_KILL,
    OP_ERASE,
    OP_STORE,
    OP_POP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       first;
  } q_entry_t;

  typedef enum logic {
    BK_IDLE,
    BK_POP
  } bk_state_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == ptr_t'(PTR_SPAN - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t ptr_dec(ptr_t p);
    return (p == '0) ? ptr_t'(PTR_SPAN - 1) : p - ptr_t'(1);
  endfunction

  function automatic ptr_t ptr_diff(ptr_t a, ptr_t b);
    logic [PTR_W:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + (PTR_W + 1)'(PTR_SPAN) - {1'b0, b};
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic slot_t slot_of(ptr_t p);
    ptr_t t;
    t = (p >= ptr_t'(BUF_DEPTH)) ? p - ptr_t'(BUF_DEPTH) : p;
    return t[SLOT_W-1:0];
  endfunction

  function automatic logic [7:0] sat8(ptr_t n);
    logic [PTR_W+7:0] w;
    w = (PTR_W + 8)'(n);
    return (w > (PTR_W + 8)'(255)) ? 8'hff : w[7:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cle_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/cle_front.sv */
// Front end of the console line editor: accepts words and classifies them into operations.
// Depends on cle_pkg.
`default_nettype none

module cle_front (
  input  wire logic             start,
  input  wire logic             busy,
  input  wire cle_pkg::in_item_t item,
  output logic                  push,
  output cle_pkg::q_entry_t     entry
);
  import cle_pkg::*;

  assign push = start && !busy;

  always_comb begin
    entry.first = item.first_of_read;
    entry.ch = (item.in_char == CH_CR) ? CH_LF : item.in_char;
    if (item.mode) begin
      entry.op = OP_POP;
    end else begin
      priority if (item.in_char == CH_NUL || item.in_char == CH_CTRL_P) begin
        entry.op = OP_NOP;
      end else if (item.in_char == CH_CTRL_U) begin
        entry.op = OP_KILL;
      end else if (item.in_char == CH_CTRL_H || item.in_char == CH_DEL) begin
        entry.op = OP_ERASE;
      end else begin
        entry.op = OP_STORE;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cle_fifo.sv */
// Short queue of classified operations between the front and back ends.
// Depends on cle_pkg.
`default_nettype none

module cle_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire cle_pkg::q_entry_t push_entry,
  input  wire logic             pop,
  output cle_pkg::q_entry_t     head,
  output logic                  empty,
  output logic                  full
);
  import cle_pkg::*;

  q_entry_t            slots [QUEUE_DEPTH];
  logic [QIDX_W-1:0]   wr_idx;
  logic [QIDX_W-1:0]   rd_idx;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign empty = (count == '0);
  assign full = (count == QCNT_W'(QUEUE_DEPTH));
  assign head = slots[rd_idx];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_idx] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_idx <= (wr_idx == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_idx + QIDX_W'(1);
      end
      if (do_pop) begin
        rd_idx <= (rd_idx == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_idx + QIDX_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cle_back.sv */
// Back end of the console line editor: owns the line store and its pointers and
// carries out queued operations. Depends on cle_pkg and cle_ram.
`default_nettype none

module cle_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire cle_pkg::q_entry_t  q_head,
  output logic                   q_pop,
  output logic                   done,
  output cle_pkg::out_item_t     result
);
  import cle_pkg::*;

  bk_state_t state;
  bk_state_t state_next;
  ptr_t      read_point;
  ptr_t      read_point_next;
  ptr_t      commit_point;
  ptr_t      commit_point_next;
  ptr_t      edit_point;
  ptr_t      edit_point_next;
  logic      pop_first;
  logic      pop_first_next;
  logic      done_next;
  out_item_t result_next;
  ptr_t      fill;
  logic      ram_we;
  logic [7:0] ram_rdata;

  cle_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_of(edit_point)),
    .wdata(q_head.ch),
    .raddr(slot_of(read_point)),
    .rdata(ram_rdata)
  );

  assign fill = ptr_diff(edit_point, read_point);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      read_point <= '0;
      commit_point <= '0;
      edit_point <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      read_point <= read_point_next;
      commit_point <= commit_point_next;
      edit_point <= edit_point_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    pop_first <= pop_first_next;
    result <= result_next;
  end

  always_comb begin
    state_next = state;
    read_point_next = read_point;
    commit_point_next = commit_point;
    edit_point_next = edit_point;
    pop_first_next = pop_first;
    done_next = 1'b0;
    result_next = '0;
    q_pop = 1'b0;
    ram_we = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          done_next = 1'b1;
          unique case (q_head.op)
            OP_NOP: begin
            end
            OP_KILL: begin
              result_next.erase_count = sat8(ptr_diff(edit_point, commit_point));
              edit_point_next = commit_point;
            end
            OP_ERASE: begin
              if (edit_point != commit_point) begin
                edit_point_next = ptr_dec(edit_point);
                result_next.erase_count = 8'd1;
              end
            end
            OP_STORE: begin
              if (fill < ptr_t'(BUF_DEPTH)) begin
                result_next.echo_valid = 1'b1;
                result_next.echo_byte = q_head.ch;
                ram_we = 1'b1;
                edit_point_next = ptr_inc(edit_point);
                if (q_head.ch == CH_LF || q_head.ch == CH_CTRL_D ||
                    fill == ptr_t'(BUF_DEPTH - 1)) begin
                  commit_point_next = ptr_inc(edit_point);
                  result_next.committed = 1'b1;
                end
              end
            end
            OP_POP: begin
              if (read_point == commit_point) begin
                result_next.read_status = RD_EMPTY;
              end else begin
                done_next = 1'b0;
                pop_first_next = q_head.first;
                state_next = BK_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BK_POP: begin
        done_next = 1'b1;
        state_next = BK_IDLE;
        if (ram_rdata == CH_CTRL_D) begin
          if (pop_first) begin
            read_point_next = ptr_inc(read_point);
          end
          result_next.read_status = RD_EOF;
        end else begin
          read_point_next = ptr_inc(read_point);
          result_next.read_status = RD_BYTE;
          result_next.read_byte = ram_rdata;
          result_next.line_end = (ram_rdata == CH_LF);
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  a_pop_finishes: assert property (@(posedge clk) disable iff (rst)
    state == BK_POP |=> done && state == BK_IDLE)
    else $error("line store read did not produce a result");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    ptr_diff(edit_point, read_point) <= ptr_t'(BUF_DEPTH))
    else $error("ring holds more than its depth");

  a_commit_inside: assert property (@(posedge clk) disable iff (rst)
    ptr_diff(commit_point, read_point) <= ptr_diff(edit_point, read_point))
    else $error("commit point lies past the edit point");

  a_commit_echoes: assert property (@(posedge clk) disable iff (rst)
    done && result.committed |-> result.echo_valid)
    else $error("commit without a stored character");

  a_line_end_byte: assert property (@(posedge clk) disable iff (rst)
    done && result.line_end |-> result.read_status == RD_BYTE && result.read_byte == CH_LF)
    else $error("line end flagged without a delivered LF");

endmodule

`default_nettype wire

/* rtl/core/console_line_editor.sv */
// Console line editor top level: canonical line buffer with editing and read pops.
// Depends on cle_pkg, cle_front, cle_fifo and cle_back.
//
// A word is taken when start is high and busy is low; each word gives exactly one
// result, shown for one cycle with done high, which the receiver cannot stall.
// Edit words (characters, backspace, Ctrl-U) finish in the back end's idle state;
// a stored-byte pop also passes BK_POP, as the line store has a registered read port.
// A taken word is registered in the queue, its result in the done and result
// registers. A two-word queue separates the classifier from the back end; busy is
// high while that queue is full. The line store needs no clearing pass after reset.
`default_nettype none

module console_line_editor (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire cle_pkg::in_item_t   item,
  output logic                    busy,
  output logic                    done,
  output cle_pkg::out_item_t      result
);
  import cle_pkg::*;

  logic     push;
  q_entry_t push_entry;
  q_entry_t q_head;
  logic     q_pop;
  logic     q_empty;
  logic     q_full;

  assign busy = q_full;

  cle_front u_front (
    .start(start),
    .busy (busy),
    .item (item),
    .push (push),
    .entry(push_entry)
  );

  cle_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  cle_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .q_head (q_head),
    .q_pop  (q_pop),
    .done   (done),
    .result (result)
  );

endmodule

`default_nettype wire

/* sim/console_line_editor_tb.sv */
`timescale 1ns / 100ps
// Testbench for console_line_editor: a directed table, then random typing, reads and noise.
// Depends on cle_pkg and the console_line_editor RTL; results are checked by a local predictor or table.

module console_line_editor_tb;
  import cle_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_GOAL = 800;
  localparam int CALM_AFTER = 700;

  typedef struct {
    in_item_t  w;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  logic      clk;
  logic      rst;
  logic      start;
  in_item_t  item;
  logic      busy;
  logic      done;
  out_item_t result;

  logic [7:0] line_ring [BUF_DEPTH];
  int         read_at = 0;
  int         commit_at = 0;
  int         edit_at = 0;

  out_item_t pending_results [$];
  stim_row_t plan [$];
  int        words_sent = 0;
  int        results_seen = 0;
  int        err_cnt = 0;
  int        bytes_read = 0;
  int        eof_seen = 0;
  int        drops_seen = 0;
  int        stall_cycles = 0;
  int        gap_odds = 4;
  bit        first_next = 1'b1;

  console_line_editor i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int ring_fill(int a, int b);
    return (a - b + PTR_SPAN) % PTR_SPAN;
  endfunction

  function automatic out_item_t predict_line_edit(in_item_t w);
    out_item_t  r;
    logic [7:0] c;
    int         n;
    r = '0;
    if (w.mode == 1'b0) begin
      c = w.in_char;
      if (c == CH_NUL || c == CH_CTRL_P) begin
        r = '0;
      end else if (c == CH_CTRL_U) begin
        n = ring_fill(edit_at, commit_at);
        r.erase_count = (n > 255) ? 8'hff : 8'(n);
        edit_at = commit_at;
      end else if (c == CH_CTRL_H || c == CH_DEL) begin
        if (edit_at != commit_at) begin
          edit_at = (edit_at + PTR_SPAN - 1) % PTR_SPAN;
          r.erase_count = 8'd1;
        end
      end else if (ring_fill(edit_at, read_at) < BUF_DEPTH) begin
        if (c == CH_CR) begin
          c = CH_LF;
        end
        r.echo_valid = 1'b1;
        r.echo_byte = c;
        line_ring[edit_at % BUF_DEPTH] = c;
        edit_at = (edit_at + 1) % PTR_SPAN;
        if (c == CH_LF || c == CH_CTRL_D || ring_fill(edit_at, read_at) == BUF_DEPTH) begin
          commit_at = edit_at;
          r.committed = 1'b1;
        end
      end else begin
        drops_seen++;
      end
    end else if (read_at == commit_at) begin
      r.read_status = RD_EMPTY;
    end else begin
      c = line_ring[read_at % BUF_DEPTH];
      if (c == CH_CTRL_D) begin
        r.read_status = RD_EOF;
        if (w.first_of_read) begin
          read_at = (read_at + 1) % PTR_SPAN;
        end
      end else begin
        read_at = (read_at + 1) % PTR_SPAN;
        r.read_status = RD_BYTE;
        r.read_byte = c;
        r.line_end = (c == CH_LF);
      end
    end
    return r;
  endfunction

  function automatic stim_row_t row(bit m, logic [7:0] c, bit f, bit typed = 1'b0,
                                    out_item_t res = '0);
    stim_row_t s;
    s.w = {m, c, f};
    s.typed = typed;
    s.res = res;
    return s;
  endfunction

  task automatic send_word(in_item_t w, out_item_t typed_res, bit typed);
    out_item_t r;
    if (words_sent < CALM_AFTER && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_line_edit(w);
    pending_results.push_back(typed ? typed_res : r);
    words_sent++;
    if (w.mode) begin
      first_next = !(r.read_status == RD_BYTE && !r.line_end);
      if (r.read_status == RD_BYTE) bytes_read++;
      if (r.read_status == RD_EOF) eof_seen++;
    end
  endtask

  task automatic type_char(logic [7:0] c);
    send_word({1'b0, c, 1'($urandom_range(0, 1))}, '0, 1'b0);
  endtask

  task automatic pop_byte();
    send_word({1'b1, 8'($urandom_range(0, 255)), first_next}, '0, 1'b0);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic read_committed(int limit);
    int n;
    n = 0;
    while (read_at != commit_at && n < limit) begin
      pop_byte();
      n++;
    end
    if ($urandom_range(0, 2) == 0) pop_byte();
  endtask

  task automatic type_line();
    int r;
    repeat ($urandom_range(0, 24)) begin
      r = $urandom_range(0, 29);
      if (r == 0) type_char(CH_CTRL_H);
      else if (r == 1) type_char(CH_DEL);
      else if (r == 2) type_char(CH_CTRL_U);
      else if (r == 3) type_char(8'($urandom_range(8'h80, 8'hff)));
      else type_char(8'($urandom_range(8'h20, 8'h7e)));
    end
    r = $urandom_range(0, 3);
    type_char(r == 0 ? CH_CTRL_D : (r == 1 ? CH_LF : CH_CR));
  endtask

  task automatic fill_ring();
    while (ring_fill(edit_at, read_at) < BUF_DEPTH) type_char(8'($urandom_range(8'h20, 8'h7e)));
    repeat (3) type_char(8'($urandom_range(8'h20, 8'h7e)));
    type_char(CH_CTRL_U);
    type_char(CH_DEL);
    read_committed(2 * BUF_DEPTH);
  endtask

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst && done) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no word outstanding");
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("echo_valid", 8'(exp_r.echo_valid), 8'(result.echo_valid));
        check_field("echo_byte", exp_r.echo_byte, result.echo_byte);
        check_field("erase_count", exp_r.erase_count, result.erase_count);
        check_field("committed", 8'(exp_r.committed), 8'(result.committed));
        check_field("read_status", 8'(exp_r.read_status), 8'(result.read_status));
        check_field("read_byte", exp_r.read_byte, result.read_byte);
        check_field("line_end", 8'(exp_r.line_end), 8'(result.line_end));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles.", WATCHDOG_LIMIT);
      $display("console_line_editor_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    out_item_t empty_res;
    int        pick;
    int        scen;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    empty_res = '0;
    empty_res.read_status = RD_EMPTY;
    plan.push_back(row(1'b1, 8'h00, 1'b1, 1'b1, empty_res));
    plan.push_back(row(1'b0, CH_NUL, 1'b0, 1'b1));
    plan.push_back(row(1'b0, CH_CTRL_P, 1'b1, 1'b1));
    plan.push_back(row(1'b0, CH_CTRL_H, 1'b0, 1'b1));
    plan.push_back(row(1'b0, CH_DEL, 1'b0, 1'b1));
    plan.push_back(row(1'b0, CH_CTRL_U, 1'b0, 1'b1));
    plan.push_back(row(1'b0, 8'h61, 1'b1));
    plan.push_back(row(1'b0, 8'hff, 1'b0));
    plan.push_back(row(1'b0, CH_DEL, 1'b0));
    plan.push_back(row(1'b0, 8'h62, 1'b0));
    plan.push_back(row(1'b0, 8'h80, 1'b0));
    plan.push_back(row(1'b0, CH_CTRL_U, 1'b0));
    plan.push_back(row(1'b0, 8'h78, 1'b0));
    plan.push_back(row(1'b0, CH_CR, 1'b0));
    plan.push_back(row(1'b1, 8'h00, 1'b1));
    plan.push_back(row(1'b1, 8'hff, 1'b0));
    plan.push_back(row(1'b1, 8'h00, 1'b0));
    plan.push_back(row(1'b0, CH_CTRL_D, 1'b0));
    plan.push_back(row(1'b1, 8'h00, 1'b0));
    plan.push_back(row(1'b1, 8'h00, 1'b0));
    plan.push_back(row(1'b1, 8'h00, 1'b1));
    plan.push_back(row(1'b1, 8'hff, 1'b1));
    plan.push_back(row(1'b0, 8'h7a, 1'b1));
    plan.push_back(row(1'b0, CH_LF, 1'b0));
    plan.push_back(row(1'b1, 8'h55, 1'b1));
    plan.push_back(row(1'b1, 8'haa, 1'b0));
    foreach (plan[i]) send_word(plan[i].w, plan[i].res, plan[i].typed);
    wait_for_results();

    scen = 0;
    first_next = 1'b1;
    while (words_sent < ITEM_GOAL) begin
      gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 6);
      pick = $urandom_range(0, 19);
      if (scen == 2 || pick == 0) begin
        fill_ring();
      end else if (pick < 4) begin
        repeat ($urandom_range(1, 8)) begin
          send_word({1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1))}, '0, 1'b0);
        end
      end else begin
        type_line();
        if ($urandom_range(0, 3) != 0) begin
          read_committed(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 2 * BUF_DEPTH);
        end
      end
      if ($urandom_range(0, 14) == 0) wait_for_results();
      scen++;
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    $display("Ran %0d words and checked %0d results over %0d scenarios.", words_sent,
             results_seen, scen);
    $display("Reads gave %0d bytes and %0d end-of-file reports; %0d characters hit a full ring.",
             bytes_read, eof_seen, drops_seen);
    if (err_cnt == 0) begin
      $display("console_line_editor_tb OK");
    end else begin
      $display("console_line_editor_tb NOT OK");
    end
    $finish;
  end

endmodule

/* console_line_editor.f */
rtl/core/cle_pkg.sv
rtl/core/cle_ram.sv
rtl/core/cle_front.sv
rtl/core/cle_fifo.sv
rtl/core/cle_back.sv
rtl/core/console_line_editor.sv
sim/console_line_editor_tb.sv
